// File: rtl/aofb_pkg.sv
`default_nettype none
package aofb_pkg;
    localparam int BlockBytes = 16;
    localparam int KeyWords   = 8;

    // register indexes on the config port
    localparam logic [2:0] RegKey0  = 3'd0;
    localparam logic [2:0] RegKey1  = 3'd1;
    localparam logic [2:0] RegKey2  = 3'd2;
    localparam logic [2:0] RegKey3  = 3'd3;
    localparam logic [2:0] RegIvHi  = 3'd4;
    localparam logic [2:0] RegIvLo  = 3'd5;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] s [256];
        s = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return s[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] byte_at(input t_block s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // SubBytes + ShiftRows, byte 0 = MSB
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox(byte_at(s, r + 4*((c + r) % 4)));
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c + 1);
            a2 = byte_at(s, 4*c + 2);
            a3 = byte_at(s, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_block byte_reverse(input t_block s);
        t_block t;
        for (int j = 0; j < BlockBytes; j++) begin
            t[127 - 8*j -: 8] = byte_at(s, BlockBytes - 1 - j);
        end
        return t;
    endfunction
endpackage
`default_nettype wire

// File: rtl/aofb_ram.sv
`default_nettype none
module aofb_ram #(
    parameter int Width = 64,
    parameter int Depth = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/aes256_ofb_masked_keystream_core.sv
// channel | dir | handshake          | fields
// in      | in  | i_valid / o_stall  | plain_high/low, byte_count, first/last_block
// out     | out | o_valid / i_stall  | cipher_high/low, valid_bytes, end_of_message
// cfg     | in  | APB psel/penable   | key_word0..3, iv_high, iv_low at 8*i
// The key schedule runs after reset and after every key write: a load step,
// then the 60 32-bit schedule words one at a time, writing 128-bit round keys
// into a 15-entry memory; no word is taken meanwhile. A block first reads
// round key 0 from the registered-read memory, then runs one round per step,
// the last round loading the output register.
// Sync reset clears control and the chaining value. A stalled output holds;
// a new word is taken only when the output register is free.
`default_nettype none
module aes256_ofb_masked_keystream_core
    import aofb_pkg::*;
#(
    parameter int ROUNDS = 14
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_plain_high,
    input  wire logic [63:0] i_plain_low,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic        i_first_block,
    input  wire logic        i_last_block,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [63:0] o_cipher_high,
    output logic      [63:0] o_cipher_low,
    output logic      [4:0]  o_valid_bytes,
    output logic             o_end_of_message
);
    localparam int NumRk  = ROUNDS + 1;
    localparam int RkAw   = $clog2(NumRk);
    localparam int TotW   = 4 * NumRk;
    localparam int WAw    = $clog2(TotW + 1);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StExp  = 2'd1;
    localparam logic [1:0] StRun  = 2'd2;

    logic [63:0] r_key [4];
    logic [63:0] r_iv_hi, r_iv_lo;
    logic        r_key_dirty;

    // config writes
    logic       cfg_we;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                RegKey0: r_key[0] <= pwdata;
                RegKey1: r_key[1] <= pwdata;
                RegKey2: r_key[2] <= pwdata;
                RegKey3: r_key[3] <= pwdata;
                RegIvHi: r_iv_hi  <= pwdata;
                RegIvLo: r_iv_lo  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            RegKey0: prdata = r_key[0];
            RegKey1: prdata = r_key[1];
            RegKey2: prdata = r_key[2];
            RegKey3: prdata = r_key[3];
            RegIvHi: prdata = r_iv_hi;
            RegIvLo: prdata = r_iv_lo;
            default: prdata = '0;
        endcase
    end

    // control
    logic [1:0]      r_state, n_state;
    logic [WAw-1:0]  r_wi;          // key schedule word index
    logic [31:0]     r_win [8];     // sliding window of last 8 schedule words
    logic [7:0]      r_rcon;
    logic [RkAw:0]   r_round;
    t_block          r_st;
    t_block          r_chain;
    logic [63:0]     r_ph, r_pl;
    logic [4:0]      r_cnt;
    logic            r_last;

    // round key memory, one 128-bit key per entry
    logic             rk_we;
    logic [RkAw-1:0]  rk_waddr, rk_raddr;
    t_block           rk_wdata, rk_rdata;

    aofb_ram #(.Width(128), .Depth(NumRk)) u_rk (
        .i_clk  (i_clk),
        .i_we   (rk_we),
        .i_waddr(rk_waddr),
        .i_wdata(rk_wdata),
        .i_raddr(rk_raddr),
        .o_rdata(rk_rdata)
    );

    // next schedule word
    logic [31:0] sch_t, sch_w, sch_prev;
    always_comb begin
        sch_prev = r_win[7];
        sch_t    = sch_prev;
        if (r_wi[2:0] == 3'd0) begin
            sch_t = {sbox(sch_prev[23:16]) ^ r_rcon, sbox(sch_prev[15:8]),
                     sbox(sch_prev[7:0]), sbox(sch_prev[31:24])};
        end else if (r_wi[2:0] == 3'd4) begin
            sch_t = {sbox(sch_prev[31:24]), sbox(sch_prev[23:16]),
                     sbox(sch_prev[15:8]), sbox(sch_prev[7:0])};
        end
        sch_w = r_win[0] ^ sch_t;
    end

    logic in_acc, out_acc, start_exp, fin_round;
    logic [4:0] cnt_clamp;
    t_block     blk_out, ks, ptb, ctb, mask;

    assign o_stall   = (r_state != StIdle) || r_key_dirty || o_valid;
    assign in_acc    = i_valid && !o_stall;
    assign out_acc   = o_valid && !i_stall;
    assign start_exp = (r_state == StIdle) && r_key_dirty && !o_valid;
    assign rk_raddr  = r_round[RkAw-1:0];

    // round datapath: rk_rdata holds key for round r_round-1
    always_comb begin
        t_block ss;
        ss = sub_shift(r_st);
        if (r_round == (RkAw+1)'(1)) blk_out = r_st ^ rk_rdata;
        else if (r_round == (RkAw+1)'(NumRk)) blk_out = ss ^ rk_rdata;
        else blk_out = mix_columns(ss) ^ rk_rdata;
    end
    assign fin_round = (r_state == StRun) && (r_round == (RkAw+1)'(NumRk));

    assign cnt_clamp = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
    assign ks  = blk_out ^ byte_reverse({r_iv_hi, r_iv_lo});
    assign ptb = {r_ph, r_pl} ^ ks;
    always_comb begin
        for (int j = 0; j < BlockBytes; j++) begin
            mask[127 - 8*j -: 8] = (5'(j) < r_cnt) ? 8'hff : 8'h00;
        end
        ctb = ptb & mask;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StIdle: if (start_exp) n_state = StExp;
                    else if (in_acc) n_state = StRun;
            StExp:  if (r_wi == WAw'(TotW - 1)) n_state = StIdle;
            StRun:  if (fin_round) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    // round key write: key words 0..7 straight from the window, later keys
    // from the three newest words plus the one being formed
    always_comb begin
        rk_we    = 1'b0;
        rk_waddr = r_wi[RkAw+1:2];
        rk_wdata = '0;
        if (r_state == StExp && r_wi[1:0] == 2'd3) begin
            rk_we = 1'b1;
            if (r_wi < WAw'(KeyWords)) begin
                rk_wdata = r_wi[2] ? {r_win[4], r_win[5], r_win[6], r_win[7]}
                                   : {r_win[0], r_win[1], r_win[2], r_win[3]};
            end else begin
                rk_wdata = {r_win[5], r_win[6], r_win[7], sch_w};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_key_dirty <= 1'b1;
            r_chain     <= '0;
            o_valid     <= 1'b0;
            r_round     <= '0;
            r_wi        <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_we && cfg_idx < RegIvHi) r_key_dirty <= 1'b1;
            else if (start_exp) r_key_dirty <= 1'b0;
            if (out_acc) o_valid <= 1'b0;
            if (start_exp) begin
                r_wi   <= '0;
                r_rcon <= 8'h01;
                for (int k = 0; k < 4; k++) begin
                    r_win[2*k]     <= r_key[k][63:32];
                    r_win[2*k + 1] <= r_key[k][31:0];
                end
            end
            if (r_state == StExp) begin
                r_wi <= r_wi + 1'b1;
                // words 0..7 are the key itself; window slides from word 8 on
                if (r_wi >= WAw'(KeyWords)) begin
                    for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
                    r_win[7] <= sch_w;
                    if (r_wi[2:0] == 3'd0) r_rcon <= xtime(r_rcon);
                end
            end
            if (in_acc) begin
                r_round <= '0;
                r_st    <= i_first_block ? {r_iv_hi, r_iv_lo} : r_chain;
                r_ph    <= i_plain_high;
                r_pl    <= i_plain_low;
                r_cnt   <= cnt_clamp;
                r_last  <= i_last_block;
            end
            if (r_state == StRun) begin
                r_round <= r_round + 1'b1;
                if (r_round != '0) r_st <= blk_out;
                if (fin_round) begin
                    r_chain          <= blk_out;
                    o_valid          <= 1'b1;
                    o_cipher_high    <= ctb[127:64];
                    o_cipher_low     <= ctb[63:0];
                    o_valid_bytes    <= r_cnt;
                    o_end_of_message <= r_last;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/aofb_checker.sv
`default_nettype none
module aofb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [4:0] o_valid_bytes,
    input wire logic       pready
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_valid_bytes))
        else $error("result dropped under stall");
    // one word in flight: no accept while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken with result pending");
    // an accepted word keeps the input stalled while it is processed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_valid_bytes <= 5'd16)
        else $error("byte count out of range");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind aes256_ofb_masked_keystream_core aofb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_valid_bytes(o_valid_bytes),
    .pready(pready)
);
`default_nettype wire

// File: verif/tb_aes256_ofb_masked_keystream_core.sv
`timescale 1ns / 100ps
module tb_aes256_ofb_masked_keystream_core
    import aofb_pkg::*;
();

    localparam int CycleLimit = 400000;
    localparam int SettleCycles = 60;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        eom;
    } t_cipher_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_plain_high, i_plain_low;
    logic [4:0]  i_byte_count;
    logic        i_first_block, i_last_block;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_cipher_high, o_cipher_low;
    logic [4:0]  o_valid_bytes;
    logic        o_end_of_message;

    aes256_ofb_masked_keystream_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_plain_high(i_plain_high), .i_plain_low(i_plain_low),
        .i_byte_count(i_byte_count), .i_first_block(i_first_block),
        .i_last_block(i_last_block),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cipher_high(o_cipher_high), .o_cipher_low(o_cipher_low),
        .o_valid_bytes(o_valid_bytes), .o_end_of_message(o_end_of_message)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [7:0]   sub_table [256];
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi, iv_lo;
    logic [127:0] chain;
    logic [127:0] round_key [15];

    t_cipher_word expected_cipher [$];
    int           errors;
    int           cycles;
    int           out_wait;
    bit           quiet;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = gf_double(a);
        end
        return p;
    endfunction

    // S-box from the field inverse and the affine map
    task automatic build_sub_table();
        logic [7:0] inv, r;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h01;
            if (a == 0) begin
                inv = 8'h00;
            end else begin
                for (int k = 0; k < 254; k++) inv = gf_mul(inv, a[7:0]);
            end
            r = inv;
            for (int k = 1; k < 5; k++) r = r ^ ((inv << k) | (inv >> (8 - k)));
            sub_table[a] = r ^ 8'h63;
        end
    endtask

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]],
                sub_table[w[7:0]]};
    endfunction

    task automatic expand_round_keys();
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [255:0] k;
        logic [7:0]   rc;
        k  = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
        rc = 8'h01;
        for (int i = 0; i < 8; i++) w[i] = k[255 - 32*i -: 32];
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t  = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (i % 8 == 4) begin
                t = sub_word(t);
            end
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ round_key[0][127 - 8*i -: 8];
        for (int r = 1; r <= 14; r++) begin
            // substitute and shift rows
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++) t[q + 4*c] = sub_table[s[q + 4*((c + q) % 4)]];
            // mix columns except in the last round
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (r < 14) begin
                    t[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[r][127 - 8*i -: 8];
        end
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
        return res;
    endfunction

    // one OFB step: advance the chain and mask the plaintext
    task automatic ofb_predict(input logic [63:0] ph, input logic [63:0] pl,
                               input logic [4:0] cnt, input logic first, input logic last);
        t_cipher_word e;
        logic [127:0] iv, pt, ct;
        logic [7:0]   ks;
        int           n;
        n  = (cnt > 16) ? 16 : int'(cnt);
        expand_round_keys();
        iv = {iv_hi, iv_lo};
        if (first) chain = iv;
        chain = aes_encrypt(chain);
        pt = {ph, pl};
        for (int j = 0; j < 16; j++) begin
            ks = chain[127 - 8*j -: 8] ^ iv[8*j +: 8];
            ct[127 - 8*j -: 8] = (j < n) ? (pt[127 - 8*j -: 8] ^ ks) : 8'h00;
        end
        e.hi = ct[127:64];
        e.lo = ct[63:0];
        e.nbytes = n[4:0];
        e.eom = last;
        expected_cipher.push_back(e);
    endtask

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("cipher word %s: got %h want %h", field, got, want);
        errors++;
    endtask

    // output side: compare and draw the next stall
    always @(posedge i_clk) begin
        t_cipher_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cipher.size() == 0) begin
                report("unexpected", o_cipher_high, 64'h0);
            end else begin
                e = expected_cipher.pop_front();
                if (o_cipher_high !== e.hi) report("cipher_high", o_cipher_high, e.hi);
                if (o_cipher_low !== e.lo) report("cipher_low", o_cipher_low, e.lo);
                if (o_valid_bytes !== e.nbytes)
                    report("valid_bytes", 64'(o_valid_bytes), 64'(e.nbytes));
                if (o_end_of_message !== e.eom)
                    report("end_of_message", 64'(o_end_of_message), 64'(e.eom));
            end
            out_wait = quiet ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (out_wait > 0);
        if (out_wait > 0) out_wait--;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("aes256_ofb_masked_keystream_core: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegKey0: key_reg[0] = val;
            RegKey1: key_reg[1] = val;
            RegKey2: key_reg[2] = val;
            RegKey3: key_reg[3] = val;
            RegIvHi: iv_hi = val;
            RegIvLo: iv_lo = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] vh, input logic [63:0] vl);
        write_reg(RegKey0, k0);
        write_reg(RegKey1, k1);
        write_reg(RegKey2, k2);
        write_reg(RegKey3, k3);
        write_reg(RegIvHi, vh);
        write_reg(RegIvLo, vl);
    endtask

    // send one word, with a random gap in front unless quiet
    task automatic send_word(input logic [63:0] ph, input logic [63:0] pl,
                             input logic [4:0] cnt, input logic first, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_plain_high <= ph; i_plain_low <= pl; i_byte_count <= cnt;
        i_first_block <= first; i_last_block <= last;
        do @(posedge i_clk); while (o_stall);
        ofb_predict(ph, pl, cnt, first, last);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_cipher.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // zero key, no first block yet: chain from reset is encrypted
    task automatic test_reset_chain();
        send_word('0, '0, 5'd16, 1'b0, 1'b0);
        send_word('1, '1, 5'd16, 1'b0, 1'b1);
        drain();
    endtask

    // byte counts: zero, short, full and above sixteen
    task automatic test_byte_counts();
        logic [4:0] cnts [8];
        cnts = '{5'd0, 5'd1, 5'd7, 5'd15, 5'd16, 5'd17, 5'd31, 5'd8};
        write_all('1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 8; i++)
            send_word('1, '1, cnts[i], i == 0, i == 7);
        drain();
        write_all('0, '0, '0, '0, '0, '0);
        send_word('0, '1, 5'd16, 1'b1, 1'b0);
        send_word(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 1'b0, 1'b1);
        drain();
    endtask

    // key changed in the middle of a message; chain carries on
    task automatic test_key_change();
        write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        send_word(rand64(), rand64(), 5'd16, 1'b1, 1'b0);
        send_word(rand64(), rand64(), 5'd16, 1'b0, 1'b0);
        drain();
        write_reg(RegKey2, rand64());
        send_word(rand64(), rand64(), 5'd16, 1'b0, 1'b0);
        drain();
        write_reg(RegIvLo, rand64());
        send_word(rand64(), rand64(), 5'd3, 1'b0, 1'b1);
        send_word(rand64(), rand64(), 5'd16, 1'b1, 1'b1);
        drain();
    endtask

    // messages with random content, some noise, key phases in between
    task automatic test_random_messages(input int total);
        int sent, len;
        logic [4:0] cnt;
        sent = 0;
        while (sent < total) begin
            if (sent % 240 < 8 && sent > 0) begin
                drain();
                write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            end
            quiet = ($urandom_range(0, 5) == 0);
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    cnt = 5'($urandom_range(0, 31));
                    send_word(rand64(), rand64(), cnt, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else begin
                    cnt = (i == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16;
                    send_word(rand64(), rand64(), cnt, i == 0, i == len - 1);
                end
                sent++;
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        errors = 0; cycles = 0; out_wait = 0; quiet = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_plain_high = '0; i_plain_low = '0; i_byte_count = 5'd16;
        i_first_block = 1'b0; i_last_block = 1'b0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        iv_hi = '0; iv_lo = '0; chain = '0;
        build_sub_table();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SettleCycles) @(negedge i_clk);

        test_reset_chain();
        test_byte_counts();
        test_key_change();
        test_random_messages(730);

        if (errors == 0) begin
            $display("aes256_ofb_masked_keystream_core: match");
        end else begin
            $display("aes256_ofb_masked_keystream_core: mismatch");
        end
        $finish;
    end
endmodule
